[design/f12te_pkg.sv]
// Shared types and constants of the FAT12 allocation table engine.
package f12te_pkg;

   localparam int OFFSET_W  = 14;
   localparam int CLUSTER_W = 13;

   localparam logic [11:0] ENTRY_MASK = 12'hFFF;
   localparam logic [7:0]  LOW_NIB    = 8'h0F;
   localparam logic [7:0]  HIGH_NIB   = 8'hF0;

   localparam logic [2:0] OP_READ_ENTRY  = 3'd0;
   localparam logic [2:0] OP_WRITE_ENTRY = 3'd1;
   localparam logic [2:0] OP_LINK_CHAIN  = 3'd2;
   localparam logic [2:0] OP_WRITE_BYTE  = 3'd3;
   localparam logic [2:0] OP_READ_BYTE   = 3'd4;

   localparam logic CSR_TABLE_LENGTH = 1'b0;
   localparam logic CSR_END_OF_CHAIN = 1'b1;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [11:0] cluster_number;
      logic [11:0] entry_value;
      logic [11:0] chain_length;
      logic [10:0] byte_address;
      logic [7:0]  byte_in;
   } req_type;

   typedef struct packed {
      logic [11:0] entry_out;
      logic [7:0]  byte_out;
      logic        in_range;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_NONE        = 3'd0,
      CMD_READ_ENTRY  = 3'd1,
      CMD_WRITE_ENTRY = 3'd2,
      CMD_LINK_CHAIN  = 3'd3,
      CMD_WRITE_BYTE  = 3'd4,
      CMD_READ_BYTE   = 3'd5
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [11:0]  cluster;
      logic [11:0]  value;
      logic [11:0]  length;
      logic [10:0]  byte_address;
      logic [7:0]   byte_in;
      logic         byte_ok;
   } cmd_type;

   typedef struct packed {
      logic [11:0] end_of_chain;
      logic [12:0] eff_length;
   } cfg_type;

endpackage

[design/f12te_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module f12te_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/f12te_front.sv]
// Front stage: accepts request words, decodes the opcode and checks raw byte addresses.
module f12te_front #(
   parameter int TABLE_DEPTH = 2048
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  f12te_pkg::req_type  req_data,
   output logic                push_valid,
   input  logic                push_ready,
   output f12te_pkg::cmd_type  push_cmd
);

   logic               hold_valid_ff, hold_valid_in;
   f12te_pkg::cmd_type hold_cmd_ff, hold_cmd_in;
   f12te_pkg::cmd_type decoded;
   logic               accept;

   assign req_stall = hold_valid_ff && !push_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      decoded.cluster      = req_data.cluster_number;
      decoded.value        = req_data.entry_value;
      decoded.length       = req_data.chain_length;
      decoded.byte_address = req_data.byte_address;
      decoded.byte_in      = req_data.byte_in;
      decoded.byte_ok      = 32'(req_data.byte_address) < TABLE_DEPTH;
      case (req_data.opcode)
         f12te_pkg::OP_READ_ENTRY: begin
            decoded.kind = f12te_pkg::CMD_READ_ENTRY;
         end
         f12te_pkg::OP_WRITE_ENTRY: begin
            decoded.kind = f12te_pkg::CMD_WRITE_ENTRY;
         end
         f12te_pkg::OP_LINK_CHAIN: begin
            decoded.kind = f12te_pkg::CMD_LINK_CHAIN;
         end
         f12te_pkg::OP_WRITE_BYTE: begin
            decoded.kind = f12te_pkg::CMD_WRITE_BYTE;
         end
         f12te_pkg::OP_READ_BYTE: begin
            decoded.kind = f12te_pkg::CMD_READ_BYTE;
         end
         default: begin
            decoded.kind = f12te_pkg::CMD_NONE;
         end
      endcase
   end

   always_comb begin
      hold_valid_in = hold_valid_ff && !push_ready;
      hold_cmd_in   = hold_cmd_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_cmd_in   = decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

   assign push_valid = hold_valid_ff;
   assign push_cmd   = hold_cmd_ff;

endmodule

[design/f12te_queue.sv]
// Two-entry command queue between the front stage and the back unit.
module f12te_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  f12te_pkg::cmd_type push_cmd,
   output logic               pop_valid,
   input  logic               pop_ready,
   output f12te_pkg::cmd_type pop_cmd
);

   f12te_pkg::cmd_type slot_ff [2];
   logic               head_ff, head_in;
   logic [1:0]         count_ff, count_in;
   logic               tail;
   logic               do_push, do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_cmd    = slot_ff[head_ff];
   assign tail       = head_ff ^ count_ff[0];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      head_in  = do_pop ? !head_ff : head_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[tail] <= push_cmd;
      end
   end

endmodule

[design/f12te_back.sv]
// Back unit: carries out table commands on the byte RAM and registers the response word.
module f12te_back #(
   parameter int TABLE_DEPTH = 2048
) (
   input  logic               clock,
   input  logic               reset,
   input  f12te_pkg::cfg_type cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  f12te_pkg::cmd_type pop_cmd,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output f12te_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int OW = f12te_pkg::OFFSET_W;
   localparam int CW = f12te_pkg::CLUSTER_W;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_BYTE = 7'b0000010,
      S_RD0  = 7'b0000100,
      S_RD1  = 7'b0001000,
      S_RD2  = 7'b0010000,
      S_WR0  = 7'b0100000,
      S_WR1  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   f12te_pkg::cmd_type cmd_ff, cmd_in;
   logic [CW-1:0]      cur_ff, cur_in;
   logic [11:0]        rem_ff, rem_in;
   logic               rng_ff, rng_in;
   logic [7:0]         low_ff, low_in;
   logic               rsp_valid_ff, rsp_valid_in;
   f12te_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic               rsp_load;
   f12te_pkg::rsp_type rsp_new;
   logic               out_free;
   logic [OW-1:0]      offset, offset_next, byte_addr_ext;
   logic               entry_ok;
   logic [CW-1:0]      cur_plus1;
   logic [11:0]        wvalue;
   logic               step_end, step_rng;

   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [7:0]         wr_data, rd_data;

   f12te_ram #(
      .WIDTH (8),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign offset        = OW'(cur_ff) + OW'(cur_ff >> 1);
   assign offset_next   = offset + OW'(1);
   assign entry_ok      = offset_next < OW'(cfg.eff_length);
   assign cur_plus1     = cur_ff + CW'(1);
   assign byte_addr_ext = OW'(pop_cmd.byte_address);

   always_comb begin
      if (cmd_ff.kind == f12te_pkg::CMD_LINK_CHAIN) begin
         wvalue = (rem_ff != 12'd1) ? (cur_plus1[11:0] & f12te_pkg::ENTRY_MASK)
                                    : cfg.end_of_chain;
      end else begin
         wvalue = cmd_ff.value;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      cur_in    = cur_ff;
      rem_in    = rem_ff;
      rng_in    = rng_ff;
      low_in    = low_ff;
      pop_ready = 1'b0;
      rsp_load  = 1'b0;
      rsp_new   = '0;
      wr_en     = 1'b0;
      wr_addr   = offset[AW-1:0];
      wr_data   = wvalue[7:0];
      rd_en     = 1'b0;
      rd_addr   = offset[AW-1:0];
      step_end  = 1'b0;
      step_rng  = rng_ff;
      case (state_ff)
         S_IDLE: begin
            if (pop_valid && out_free) begin
               pop_ready = 1'b1;
               cmd_in    = pop_cmd;
               cur_in    = CW'(pop_cmd.cluster);
               rem_in    = (pop_cmd.kind == f12te_pkg::CMD_LINK_CHAIN) ? pop_cmd.length : 12'd1;
               rng_in    = 1'b1;
               case (pop_cmd.kind)
                  f12te_pkg::CMD_WRITE_BYTE: begin
                     wr_en            = pop_cmd.byte_ok;
                     wr_addr          = byte_addr_ext[AW-1:0];
                     wr_data          = pop_cmd.byte_in;
                     rsp_load         = 1'b1;
                     rsp_new.in_range = pop_cmd.byte_ok;
                  end
                  f12te_pkg::CMD_READ_BYTE: begin
                     if (pop_cmd.byte_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = byte_addr_ext[AW-1:0];
                        state_in = S_BYTE;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  f12te_pkg::CMD_READ_ENTRY: begin
                     state_in = S_RD0;
                  end
                  f12te_pkg::CMD_WRITE_ENTRY: begin
                     state_in = S_WR0;
                  end
                  f12te_pkg::CMD_LINK_CHAIN: begin
                     if (pop_cmd.length == 12'd0) begin
                        rsp_load         = 1'b1;
                        rsp_new.in_range = 1'b1;
                     end else begin
                        state_in = S_WR0;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_BYTE: begin
            rsp_load         = 1'b1;
            rsp_new.byte_out = rd_data;
            rsp_new.in_range = 1'b1;
            state_in         = S_IDLE;
         end
         S_RD0: begin
            if (entry_ok) begin
               rd_en    = 1'b1;
               rd_addr  = offset[AW-1:0];
               state_in = S_RD1;
            end else begin
               rsp_load          = 1'b1;
               rsp_new.entry_out = cfg.end_of_chain;
               state_in          = S_IDLE;
            end
         end
         S_RD1: begin
            low_in   = rd_data;
            rd_en    = 1'b1;
            rd_addr  = offset_next[AW-1:0];
            state_in = S_RD2;
         end
         S_RD2: begin
            rsp_load          = 1'b1;
            rsp_new.entry_out = cur_ff[0] ? {rd_data, low_ff[7:4]} : {rd_data[3:0], low_ff};
            rsp_new.in_range  = 1'b1;
            state_in          = S_IDLE;
         end
         S_WR0: begin
            if (entry_ok) begin
               rd_en = 1'b1;
               wr_en = 1'b1;
               if (cur_ff[0]) begin
                  rd_addr = offset[AW-1:0];
                  wr_addr = offset_next[AW-1:0];
                  wr_data = wvalue[11:4];
               end else begin
                  rd_addr = offset_next[AW-1:0];
                  wr_addr = offset[AW-1:0];
                  wr_data = wvalue[7:0];
               end
               state_in = S_WR1;
            end else begin
               step_end = 1'b1;
               step_rng = 1'b0;
            end
         end
         S_WR1: begin
            wr_en = 1'b1;
            if (cur_ff[0]) begin
               wr_addr = offset[AW-1:0];
               wr_data = (rd_data & f12te_pkg::LOW_NIB) | {wvalue[3:0], 4'b0000};
            end else begin
               wr_addr = offset_next[AW-1:0];
               wr_data = (rd_data & f12te_pkg::HIGH_NIB) | {4'b0000, wvalue[11:8]};
            end
            step_end = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (step_end) begin
         rng_in = step_rng;
         if (rem_ff == 12'd1) begin
            rsp_load         = 1'b1;
            rsp_new.in_range = step_rng;
            state_in         = S_IDLE;
         end else begin
            cur_in   = cur_plus1;
            rem_in   = rem_ff - 12'd1;
            state_in = S_WR0;
         end
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = rsp_load ? rsp_new : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      cur_ff      <= cur_in;
      rem_ff      <= rem_in;
      rng_ff      <= rng_in;
      low_ff      <= low_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/fat12_table_engine_top.sv]
// Top level of the FAT12 allocation table engine with its configuration registers.
//
//   channel   direction   handshake           word
//   req       in          req_valid/stall     req_data (opcode and operands)
//   rsp       out         rsp_valid/stall     rsp_data (entry, byte, in_range)
//   csr       in          csr_we              csr_index, csr_wdata
//
// A command is taken in S_IDLE; a read entry runs S_RD0, S_RD1, S_RD2, a write entry or
// each link chain cluster S_WR0, S_WR1, a read byte S_BYTE; others and byte reads outside
// the table end in S_IDLE, entries out of range in S_RD0 or S_WR0. One RAM read port sets
// these steps. The front stage and the queue each add a register ahead of the back unit.
// Reset is synchronous; the table RAM is not cleared and holds garbage until written.
// A stalled response holds in its register while the queue keeps filling.
module fat12_table_engine_top #(
   parameter int TABLE_DEPTH = 2048
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  f12te_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output f12te_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [11:0]        csr_wdata
);

   localparam logic [12:0] DEPTH_LIMIT = 13'(TABLE_DEPTH);

   logic [11:0]        table_length_ff, table_length_in;
   logic [11:0]        end_of_chain_ff, end_of_chain_in;
   f12te_pkg::cfg_type cfg;

   logic               push_valid, push_ready, pop_valid, pop_ready;
   f12te_pkg::cmd_type push_cmd, pop_cmd;

   always_comb begin
      table_length_in = table_length_ff;
      end_of_chain_in = end_of_chain_ff;
      if (csr_we) begin
         case (csr_index)
            f12te_pkg::CSR_TABLE_LENGTH: begin
               table_length_in = csr_wdata;
            end
            f12te_pkg::CSR_END_OF_CHAIN: begin
               end_of_chain_in = csr_wdata;
            end
            default: begin
               table_length_in = table_length_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= 12'd2048;
         end_of_chain_ff <= 12'd4095;
      end else begin
         table_length_ff <= table_length_in;
         end_of_chain_ff <= end_of_chain_in;
      end
   end

   assign cfg.end_of_chain = end_of_chain_ff;
   assign cfg.eff_length   = ({1'b0, table_length_ff} < DEPTH_LIMIT) ? {1'b0, table_length_ff}
                                                                      : DEPTH_LIMIT;

   f12te_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   f12te_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   f12te_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[design/f12te_checker.sv]
// Port-level checker for the FAT12 table engine and its bind to the top level.
module f12te_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input f12te_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input f12te_pkg::rsp_type rsp_data
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request word changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response word changed");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response word right after reset");

   a_entry_byte_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.entry_out == 12'd0 || rsp_data.byte_out == 8'd0))
      else $error("response carries both an entry and a byte");

   a_byte_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_out != 8'd0 |-> rsp_data.in_range)
      else $error("byte returned from outside the table");

endmodule

bind fat12_table_engine_top f12te_checker u_checker (.*);

[dv/fat12_table_engine_top_tb.sv]
// Self-checking testbench for the FAT12 allocation table engine, directed words then random words.
`timescale 1ns / 1ps

module fat12_table_engine_top_tb;

   localparam int TABLE_DEPTH    = 2048;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int RANDOM_PHASES  = 7;
   localparam int PHASE_WORDS    = 243;
   localparam int HOLD_AT_RESULT = 640;
   localparam int HOLD_CYCLES    = 300;
   localparam int QUIET_FIRST    = 1000;
   localparam int QUIET_LAST     = 1250;

   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   typedef struct {
      bit                 is_csr;
      logic [11:0]        new_length;
      logic [11:0]        new_end;
      f12te_pkg::req_type word;
      bit                 typed;
      f12te_pkg::rsp_type answer;
   } plan_row_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   f12te_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   f12te_pkg::rsp_type rsp_data;
   logic               csr_we    = 1'b0;
   logic               csr_index = 1'b0;
   logic [11:0]        csr_wdata = '0;

   logic [7:0]  table_img [TABLE_DEPTH];
   bit          low_known [TABLE_DEPTH];
   bit          high_known [TABLE_DEPTH];
   logic [11:0] length_reg = 12'd2048;
   logic [11:0] chain_end  = 12'd4095;

   f12te_pkg::rsp_type answer_q [$];
   plan_row_type       opening_plan [$];
   int                 mismatch_count = 0;
   int                 results_seen   = 0;
   int                 words_sent     = 0;
   int                 idle_cycles    = 0;
   int                 hold_left      = 0;
   bit                 no_idle        = 1'b0;

   always #2 clock = ~clock;

   fat12_table_engine_top #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   function automatic int usable_bytes();
      return (length_reg < TABLE_DEPTH) ? int'(length_reg) : TABLE_DEPTH;
   endfunction

   function automatic bit entry_fits(int cluster);
      return cluster + cluster / 2 + 1 < usable_bytes();
   endfunction

   function automatic bit entry_readable(int cluster);
      int ofs = cluster + cluster / 2;
      if (!entry_fits(cluster)) return 1'b1;
      if (cluster % 2 == 1) return high_known[ofs] && low_known[ofs + 1] && high_known[ofs + 1];
      return low_known[ofs] && high_known[ofs] && low_known[ofs + 1];
   endfunction

   function automatic bit entry_store(int cluster, logic [11:0] value);
      int ofs = cluster + cluster / 2;
      if (!entry_fits(cluster)) return 1'b0;
      if (cluster % 2 == 1) begin
         table_img[ofs]     = {value[3:0], table_img[ofs][3:0]};
         table_img[ofs + 1] = value[11:4];
         high_known[ofs]     = 1'b1;
         low_known[ofs + 1]  = 1'b1;
         high_known[ofs + 1] = 1'b1;
      end else begin
         table_img[ofs]     = value[7:0];
         table_img[ofs + 1] = {table_img[ofs + 1][7:4], value[11:8]};
         low_known[ofs]     = 1'b1;
         high_known[ofs]    = 1'b1;
         low_known[ofs + 1] = 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic f12te_pkg::rsp_type fat_execute(f12te_pkg::req_type w);
      f12te_pkg::rsp_type r = '0;
      int                 cl = w.cluster_number;
      int                 ofs = cl + cl / 2;
      int                 len = w.chain_length;
      logic [11:0]        link;
      case (w.opcode)
         f12te_pkg::OP_READ_ENTRY: begin
            r.in_range = entry_fits(cl);
            if (!r.in_range) r.entry_out = chain_end;
            else if (cl % 2 == 1) r.entry_out = {table_img[ofs + 1], table_img[ofs][7:4]};
            else r.entry_out = {table_img[ofs + 1][3:0], table_img[ofs]};
         end
         f12te_pkg::OP_WRITE_ENTRY: begin
            r.in_range = entry_store(cl, w.entry_value);
         end
         f12te_pkg::OP_LINK_CHAIN: begin
            r.in_range = 1'b1;
            for (int i = 0; i < len; i++) begin
               link = (i + 1 < len) ? 12'(cl + i + 1) : chain_end;
               if (!entry_store(cl + i, link)) r.in_range = 1'b0;
            end
         end
         f12te_pkg::OP_WRITE_BYTE: begin
            table_img[w.byte_address]  = w.byte_in;
            low_known[w.byte_address]  = 1'b1;
            high_known[w.byte_address] = 1'b1;
            r.in_range = 1'b1;
         end
         f12te_pkg::OP_READ_BYTE: begin
            r.byte_out = table_img[w.byte_address];
            r.in_range = 1'b1;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic f12te_pkg::req_type random_request();
      f12te_pkg::req_type w;
      logic [63:0]        noise;
      int                 pick;
      int                 rim;
      noise = {$urandom, $urandom};
      w = noise[$bits(f12te_pkg::req_type)-1:0];
      rim = usable_bytes() * 2 / 3;
      pick = $urandom_range(99);
      if (pick < 28) w.opcode = f12te_pkg::OP_READ_ENTRY;
      else if (pick < 52) w.opcode = f12te_pkg::OP_WRITE_ENTRY;
      else if (pick < 66) w.opcode = f12te_pkg::OP_LINK_CHAIN;
      else if (pick < 80) w.opcode = f12te_pkg::OP_WRITE_BYTE;
      else if (pick < 95) w.opcode = f12te_pkg::OP_READ_BYTE;
      else w.opcode = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      pick = $urandom_range(99);
      if (pick < 70) w.cluster_number = 12'($urandom_range(63));
      else if (pick < 82) w.cluster_number = 12'((rim < 3) ? $urandom_range(3)
                                                        : rim - 3 + $urandom_range(6));
      pick = $urandom_range(99);
      if (pick < 70) w.byte_address = 11'($urandom_range(95));
      else if (pick < 80) w.byte_address = 11'($urandom_range(2047, 2040));
      if (w.opcode == f12te_pkg::OP_LINK_CHAIN && $urandom_range(99) >= 3)
         w.chain_length = 12'($urandom_range(8));
      if (w.opcode == f12te_pkg::OP_READ_ENTRY && !entry_readable(w.cluster_number))
         w.opcode = f12te_pkg::OP_WRITE_ENTRY;
      if (w.opcode == f12te_pkg::OP_READ_BYTE &&
          !(low_known[w.byte_address] && high_known[w.byte_address]))
         w.opcode = f12te_pkg::OP_WRITE_BYTE;
      return w;
   endfunction

   function automatic f12te_pkg::req_type word(logic [2:0] op, logic [11:0] cl,
                                               logic [11:0] val, logic [11:0] len,
                                               logic [10:0] addr, logic [7:0] data);
      return '{opcode: op, cluster_number: cl, entry_value: val, chain_length: len,
               byte_address: addr, byte_in: data};
   endfunction

   function automatic f12te_pkg::rsp_type answer(logic [11:0] e, logic [7:0] b, logic r);
      return '{entry_out: e, byte_out: b, in_range: r};
   endfunction

   function automatic void plan_word(f12te_pkg::req_type w, bit typed, f12te_pkg::rsp_type a);
      plan_row_type row;
      row.is_csr     = 1'b0;
      row.new_length = '0;
      row.new_end    = '0;
      row.word       = w;
      row.typed      = typed;
      row.answer     = a;
      opening_plan.push_back(row);
   endfunction

   function automatic void plan_config(logic [11:0] len, logic [11:0] eoc);
      plan_row_type row;
      row.is_csr     = 1'b1;
      row.new_length = len;
      row.new_end    = eoc;
      row.word       = '0;
      row.typed      = 1'b0;
      row.answer     = '0;
      opening_plan.push_back(row);
   endfunction

   task automatic send_word(input f12te_pkg::req_type w, input bit typed,
                            input f12te_pkg::rsp_type known);
      f12te_pkg::rsp_type predicted;
      while (!no_idle && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = fat_execute(w);
      answer_q.push_back(typed ? known : predicted);
      words_sent++;
   endtask

   // Registers change only once every expected word has come back and the engine is quiet.
   task automatic set_config(input logic [11:0] len, input logic [11:0] eoc);
      req_valid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= f12te_pkg::CSR_TABLE_LENGTH;
      csr_wdata <= len;
      @(posedge clock);
      csr_index <= f12te_pkg::CSR_END_OF_CHAIN;
      csr_wdata <= eoc;
      @(posedge clock);
      csr_we     <= 1'b0;
      length_reg  = len;
      chain_end   = eoc;
   endtask

   task automatic check_answer(input f12te_pkg::rsp_type got);
      f12te_pkg::rsp_type want;
      if (answer_q.size() == 0) begin
         $display("%0t: unexpected word entry_out=%h byte_out=%h in_range=%b",
                  $time, got.entry_out, got.byte_out, got.in_range);
         mismatch_count++;
         return;
      end
      want = answer_q.pop_front();
      if (got.entry_out !== want.entry_out) begin
         $display("%0t: entry_out expected %h actual %h", $time, want.entry_out, got.entry_out);
         mismatch_count++;
      end
      if (got.byte_out !== want.byte_out) begin
         $display("%0t: byte_out expected %h actual %h", $time, want.byte_out, got.byte_out);
         mismatch_count++;
      end
      if (got.in_range !== want.in_range) begin
         $display("%0t: in_range expected %b actual %b", $time, want.in_range, got.in_range);
         mismatch_count++;
      end
   endtask

   // The receiver holds off once for a long stretch so the engine fills and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_answer(rsp_data);
            results_seen++;
            if (results_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < 10);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      plan_word(word(f12te_pkg::OP_WRITE_BYTE, 12'd0, 12'd0, 12'd0, 11'd0, 8'hA5), 1'b1,
                answer(12'd0, 8'd0, 1'b1));
      plan_word(word(f12te_pkg::OP_WRITE_BYTE, 12'd0, 12'd0, 12'd0, 11'd2047, 8'hFF), 1'b1,
                answer(12'd0, 8'd0, 1'b1));
      plan_word(word(f12te_pkg::OP_READ_BYTE, 12'd0, 12'd0, 12'd0, 11'd2047, 8'd0), 1'b1,
                answer(12'd0, 8'hFF, 1'b1));
      plan_word(word(f12te_pkg::OP_READ_BYTE, 12'd0, 12'd0, 12'd0, 11'd0, 8'd0), 1'b1,
                answer(12'd0, 8'hA5, 1'b1));
      plan_word(word(f12te_pkg::OP_WRITE_ENTRY, 12'd0, 12'hFFF, 12'd0, 11'd0, 8'd0), 1'b1,
                answer(12'd0, 8'd0, 1'b1));
      plan_word(word(f12te_pkg::OP_READ_ENTRY, 12'd0, 12'd0, 12'd0, 11'd0, 8'd0), 1'b1,
                answer(12'hFFF, 8'd0, 1'b1));
      plan_word(word(f12te_pkg::OP_WRITE_ENTRY, 12'd1, 12'h000, 12'd0, 11'd0, 8'd0), 1'b1,
                answer(12'd0, 8'd0, 1'b1));
      plan_word(word(f12te_pkg::OP_READ_ENTRY, 12'd1, 12'd0, 12'd0, 11'd0, 8'd0), 1'b1,
                answer(12'd0, 8'd0, 1'b1));
      plan_word(word(f12te_pkg::OP_READ_BYTE, 12'd0, 12'd0, 12'd0, 11'd1, 8'd0), 1'b1,
                answer(12'd0, 8'h0F, 1'b1));
      plan_word(word(f12te_pkg::OP_READ_ENTRY, 12'hFFF, 12'hFFF, 12'hFFF, 11'h7FF, 8'hFF), 1'b1,
                answer(12'hFFF, 8'd0, 1'b0));
      plan_word(word(f12te_pkg::OP_WRITE_ENTRY, 12'hFFF, 12'hFFF, 12'd0, 11'd0, 8'd0), 1'b1,
                answer(12'd0, 8'd0, 1'b0));
      plan_word(word(f12te_pkg::OP_WRITE_ENTRY, 12'd1364, 12'h5A3, 12'd0, 11'd0, 8'd0), 1'b1,
                answer(12'd0, 8'd0, 1'b1));
      plan_word(word(f12te_pkg::OP_READ_ENTRY, 12'd1364, 12'd0, 12'd0, 11'd0, 8'd0), 1'b1,
                answer(12'h5A3, 8'd0, 1'b1));
      plan_word(word(f12te_pkg::OP_READ_ENTRY, 12'd1365, 12'd0, 12'd0, 11'd0, 8'd0), 1'b1,
                answer(12'hFFF, 8'd0, 1'b0));
      plan_word(word(f12te_pkg::OP_LINK_CHAIN, 12'd10, 12'd0, 12'd0, 11'd0, 8'd0), 1'b1,
                answer(12'd0, 8'd0, 1'b1));
      plan_word(word(f12te_pkg::OP_LINK_CHAIN, 12'd2, 12'd0, 12'd5, 11'd0, 8'd0), 1'b1,
                answer(12'd0, 8'd0, 1'b1));
      plan_word(word(f12te_pkg::OP_READ_ENTRY, 12'd4, 12'd0, 12'd0, 11'd0, 8'd0), 1'b0, '0);
      plan_word(word(f12te_pkg::OP_READ_ENTRY, 12'd6, 12'd0, 12'd0, 11'd0, 8'd0), 1'b0, '0);
      plan_word(word(f12te_pkg::OP_LINK_CHAIN, 12'd4090, 12'd0, 12'd10, 11'd0, 8'd0), 1'b1,
                answer(12'd0, 8'd0, 1'b0));
      plan_word(word(OP_SPARE_FIRST, 12'hFFF, 12'hFFF, 12'hFFF, 11'h7FF, 8'hFF), 1'b1, '0);
      plan_word(word(OP_SPARE_LAST, 12'h0A5, 12'h5A0, 12'h003, 11'h055, 8'h3C), 1'b1, '0);
      plan_config(12'd0, 12'd0);
      plan_word(word(f12te_pkg::OP_READ_ENTRY, 12'd0, 12'd0, 12'd0, 11'd0, 8'd0), 1'b1,
                answer(12'd0, 8'd0, 1'b0));
      plan_word(word(f12te_pkg::OP_WRITE_ENTRY, 12'd0, 12'h123, 12'd0, 11'd0, 8'd0), 1'b1,
                answer(12'd0, 8'd0, 1'b0));
      plan_word(word(f12te_pkg::OP_WRITE_BYTE, 12'd0, 12'd0, 12'd0, 11'd5, 8'h3C), 1'b1,
                answer(12'd0, 8'd0, 1'b1));
      plan_word(word(f12te_pkg::OP_READ_BYTE, 12'd0, 12'd0, 12'd0, 11'd5, 8'd0), 1'b1,
                answer(12'd0, 8'h3C, 1'b1));
      plan_config(12'd3, 12'hABC);
      plan_word(word(f12te_pkg::OP_READ_ENTRY, 12'd1, 12'd0, 12'd0, 11'd0, 8'd0), 1'b0, '0);
      plan_word(word(f12te_pkg::OP_READ_ENTRY, 12'd2, 12'd0, 12'd0, 11'd0, 8'd0), 1'b1,
                answer(12'hABC, 8'd0, 1'b0));
      plan_word(word(f12te_pkg::OP_LINK_CHAIN, 12'd0, 12'd0, 12'd3, 11'd0, 8'd0), 1'b1,
                answer(12'd0, 8'd0, 1'b0));
      plan_config(12'd2048, 12'd4095);
      plan_word(word(f12te_pkg::OP_LINK_CHAIN, 12'd0, 12'd0, 12'hFFF, 11'd0, 8'd0), 1'b1,
                answer(12'd0, 8'd0, 1'b0));
      plan_word(word(f12te_pkg::OP_READ_ENTRY, 12'd1364, 12'd0, 12'd0, 11'd0, 8'd0), 1'b0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_plan[k]) begin
         if (opening_plan[k].is_csr) begin
            set_config(opening_plan[k].new_length, opening_plan[k].new_end);
         end else begin
            send_word(opening_plan[k].word, opening_plan[k].typed, opening_plan[k].answer);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: set_config(12'd2048, 12'd4095);
            1: set_config(12'd0, 12'd0);
            2: set_config(12'd2047, 12'($urandom));
            3: set_config(12'($urandom_range(200, 3)), 12'($urandom));
            4: set_config(12'($urandom_range(2048)), 12'($urandom));
            5: set_config(12'd1, 12'd4095);
            default: set_config(12'd2048, 12'($urandom));
         endcase
         for (int n = 0; n < PHASE_WORDS; n++) begin
            no_idle = (words_sent >= QUIET_FIRST) && (words_sent < QUIET_LAST);
            send_word(random_request(), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && answer_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
